/* rtl/site_search_window_unit_defines.svh */
// assertion macros shared by the site search window rtl
`ifndef SITE_SEARCH_WINDOW_UNIT_DEFINES_SVH
`define SITE_SEARCH_WINDOW_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define SSW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define SSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssw_pkg.sv */
// shared types and constants for the site search window unit
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int PAT_BYTES       = 16;
  localparam int LEN_W           = 6;
  localparam int PLEN_W          = 5;
  localparam int BLK_W           = 5;
  localparam int HALF_W          = 16;
  localparam int WORD_W          = 32;

  localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RST = 5'd6;
  localparam logic [HALF_W-1:0] HALF_WINDOW_RST    = 16'd500;
  localparam logic [WORD_W-1:0] SHORT_LIMIT_RST    = 32'd1000;

  typedef enum logic [2:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_LOW    = 3'd1,
    CFG_PATTERN_HIGH   = 3'd2,
    CFG_HALF_WINDOW    = 3'd3,
    CFG_SHORT_LIMIT    = 3'd4
  } cfg_reg_t;

  // first member sits in the top bits, so match_pos lands in bits 31:0
  typedef struct packed {
    logic [WORD_W-1:0] match_number;
    logic [WORD_W-1:0] range_end;
    logic [WORD_W-1:0] range_start;
    logic [WORD_W-1:0] match_pos;
  } result_t;

endpackage

`default_nettype wire

/* rtl/site_search_window_unit.sv */
// top level of the streaming site search unit with match windows
//
// usage
//   s_tvalid/s_tready/s_tdata/s_tuser carry one sequence byte per transaction;
//   s_tuser high marks the first byte of a new sequence and clears the
//   position, the match count, the overlap block and the byte history.
//   m_tvalid/m_tready/m_tdata carry one result per match found: the match
//   start, the clamped window and the ordinal of the match in the sequence.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the pattern length, the two
//   pattern words, the half window and the short limit; write only while idle.
// timing
//   one byte per cycle while s_tready is high; the result of the byte that
//   completes a match is registered in the output stage, or in the skid
//   stage while the receiver stalls. the compare of the pattern against the
//   history shift register is combinational and sits together with the window
//   arithmetic between the input handshake and the output register.
// reset and stall
//   rst (synchronous) loads the register defaults and empties the output.
//   when the receiver stalls, one more result is held in a skid stage, after
//   that s_tready drops until the receiver takes a result; none is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "site_search_window_unit_defines.svh"

module site_search_window_unit
  import ssw_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // sequence byte channel
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // base [7:0], seq_len [39:8]
  input  logic          s_tuser,   // first
  // match result channel
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // match_pos [31:0], range_start [63:32],
                                   // range_end [95:64], match_number [127:96]
  // register write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  // configuration registers
  logic [PLEN_W-1:0]    pattern_length;
  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [HALF_W-1:0]    half_window;
  logic [WORD_W-1:0]    short_limit;

  // search state
  logic [MAX_PATTERN-1:0][7:0] history;
  logic [WORD_W-1:0]    position;
  logic [BLK_W-1:0]     blocked_bytes;
  logic [WORD_W-1:0]    matches_seen;

  // input fields
  logic [7:0]           in_base;
  logic [WORD_W-1:0]    in_seq_len;
  logic                 in_first;
  logic                 accept;

  // per byte values after the new sequence clear
  logic [MAX_PATTERN-1:0][7:0] hist_next;
  logic [WORD_W-1:0]    pos_cur;
  logic [BLK_W-1:0]     blk_cur;
  logic [WORD_W-1:0]    ms_cur;

  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     len_m1;
  logic                 bytes_hit;
  logic                 enough_bytes;
  logic                 match_found;

  // window math
  logic [WORD_W-1:0]    start;
  logic [WORD_W-1:0]    hw_ext;
  logic [WORD_W:0]      hi_sum;
  logic                 is_short;
  result_t              res;
  logic                 out_room;
  result_t              out_res;

  assign in_base    = s_tdata[7:0];
  assign in_seq_len = s_tdata[39:8];
  assign in_first   = s_tuser;
  assign accept     = s_tvalid && s_tready;
  assign cfg_ready  = !rst;
  assign s_tready   = out_room && !rst;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PATTERN_LENGTH_RST;
      pattern_low    <= '0;
      pattern_high   <= '0;
      half_window    <= HALF_WINDOW_RST;
      short_limit    <= SHORT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_HALF_WINDOW:    half_window    <= cfg_data[HALF_W-1:0];
        CFG_SHORT_LIMIT:    short_limit    <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, anything past the history depth is clamped
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if ({1'b0, pattern_length} > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = {1'b0, pattern_length};
    end
  end

  assign len_m1 = eff_len - LEN_W'(1);

  // a first byte starts from cleared state
  assign pos_cur = in_first ? '0 : position;
  assign blk_cur = in_first ? '0 : blocked_bytes;
  assign ms_cur  = in_first ? '0 : matches_seen;

  always_comb begin
    hist_next[0] = in_base;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      hist_next[i] = in_first ? 8'h00 : history[i-1];
    end
  end

  ssw_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .hist    (hist_next),
    .pattern ({pattern_high, pattern_low}),
    .eff_len (eff_len),
    .hit     (bytes_hit)
  );

  // a match needs the full pattern in this sequence and no pending overlap
  assign enough_bytes = pos_cur >= WORD_W'(len_m1);
  assign match_found  = accept && (blk_cur == '0) && enough_bytes && bytes_hit;

  assign start    = pos_cur - WORD_W'(len_m1);
  assign hw_ext   = WORD_W'(half_window);
  assign hi_sum   = {1'b0, start} + {1'b0, hw_ext};
  assign is_short = in_seq_len < short_limit;

  always_comb begin
    res.match_pos    = start;
    res.match_number = ms_cur;
    if (is_short) begin
      res.range_start = '0;
      res.range_end   = in_seq_len;
    end else begin
      res.range_start = (start >= hw_ext) ? (start - hw_ext) : '0;
      res.range_end   = (hi_sum > {1'b0, in_seq_len}) ? in_seq_len : hi_sum[WORD_W-1:0];
    end
  end

  // state update per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      history       <= '0;
      position      <= '0;
      blocked_bytes <= '0;
      matches_seen  <= '0;
    end else if (accept) begin
      history  <= hist_next;
      position <= pos_cur + WORD_W'(1);
      if (match_found) begin
        blocked_bytes <= len_m1[BLK_W-1:0];
        matches_seen  <= ms_cur + WORD_W'(1);
      end else begin
        blocked_bytes <= (blk_cur != '0) ? (blk_cur - BLK_W'(1)) : '0;
        matches_seen  <= ms_cur;
      end
    end
  end

  ssw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (match_found),
    .push_data  (res),
    .push_ready (out_room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = out_res;

  `SSW_ASSERT_IMPLY(a_hit_unblocked, match_found, blk_cur == '0, "match inside a blocked span")
  `SSW_ASSERT_NEXT(a_block_after_hit, match_found, blocked_bytes == $past(len_m1[BLK_W-1:0]), "overlap block not loaded after match")
  `SSW_ASSERT_NEXT(a_count_after_hit, match_found, matches_seen == $past(ms_cur) + WORD_W'(1), "match count not advanced")
  `SSW_ASSERT_IMPLY(a_push_has_room, match_found, out_room, "result pushed into full output buffer")

endmodule

`default_nettype wire

/* rtl/ssw_match.sv */
// parallel compare of the newest history bytes against the site pattern
`timescale 1ns / 1ps
`default_nettype none

module ssw_match
  import ssw_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0][7:0] hist,
  input  logic [PAT_BYTES*8-1:0]      pattern,
  input  logic [LEN_W-1:0]            eff_len,
  output logic                        hit
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0] byte_ok;

  // pattern byte k lines up with history entry eff_len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
    logic [LEN_W-1:0] sel_full;
    logic [IDX_W-1:0] sel;
    logic [7:0]       pat_b;

    assign sel_full = eff_len - LEN_W'(k + 1);
    assign sel      = sel_full[IDX_W-1:0];

    if (k < PAT_BYTES) begin : g_pat
      assign pat_b = pattern[k*8 +: 8];
    end else begin : g_zero
      assign pat_b = 8'h00;
    end

    assign byte_ok[k] = (LEN_W'(k) >= eff_len) || (hist[sel] == pat_b);
  end

  assign hit = &byte_ok;

endmodule

`default_nettype wire

/* rtl/ssw_out_buf.sv */
// two-entry output register with skid stage for result transactions
`timescale 1ns / 1ps
`default_nettype none
`include "site_search_window_unit_defines.svh"

module ssw_out_buf
  import ssw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `SSW_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid, "skid holds data with output empty")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// scoreboard, stimulus and checks for the site search window unit
`timescale 1ns / 1ps

// tracks the search state of the unit and the matches it must report
class site_match_tracker;
  logic [4:0]       pat_len;
  logic [127:0]     pat_bytes;
  logic [15:0]      half_win;
  logic [31:0]      short_lim;
  logic [7:0]       hist [ssw_pkg::MAX_PATTERN_DEF];
  logic [31:0]      pos;
  logic [4:0]       blocked;
  logic [31:0]      seen;
  ssw_pkg::result_t pending_matches [$];
  int unsigned      fails;

  function new();
    pat_len   = ssw_pkg::PATTERN_LENGTH_RST;
    pat_bytes = '0;
    half_win  = ssw_pkg::HALF_WINDOW_RST;
    short_lim = ssw_pkg::SHORT_LIMIT_RST;
    fails     = 0;
    clear_sequence();
  endfunction

  function void clear_sequence();
    foreach (hist[k]) hist[k] = 8'h00;
    pos     = '0;
    blocked = '0;
    seen    = '0;
  endfunction

  function void write_reg(ssw_pkg::cfg_reg_t idx, logic [63:0] data);
    case (idx)
      ssw_pkg::CFG_PATTERN_LENGTH: pat_len = data[4:0];
      ssw_pkg::CFG_PATTERN_LOW:    pat_bytes[63:0] = data;
      ssw_pkg::CFG_PATTERN_HIGH:   pat_bytes[127:64] = data;
      ssw_pkg::CFG_HALF_WINDOW:    half_win = data[15:0];
      ssw_pkg::CFG_SHORT_LIMIT:    short_lim = data[31:0];
      default: ;
    endcase
  endfunction

  // one accepted sequence byte; queues the match it completes, if any
  function void note_byte(logic [7:0] b, logic [31:0] slen, logic first);
    int unsigned       len;
    int unsigned       k;
    longint unsigned   at;
    longint unsigned   site_at;
    longint unsigned   lo;
    longint unsigned   hi;
    bit                hit;
    ssw_pkg::result_t  r;
    len = 32'(pat_len);
    if (len < 1) len = 1;
    if (len > ssw_pkg::MAX_PATTERN_DEF) len = ssw_pkg::MAX_PATTERN_DEF;
    if (first) clear_sequence();
    for (k = ssw_pkg::MAX_PATTERN_DEF - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    at = 64'(pos);
    pos = pos + 32'd1;
    // bytes inside the previous match cannot end a new one
    if (blocked != 0) begin
      blocked = blocked - 5'd1;
      return;
    end
    if (at + 1 < len) return;
    hit = 1'b1;
    for (k = 0; k < len; k++) begin
      if (hist[len-1-k] != pat_bytes[8*k +: 8]) hit = 1'b0;
    end
    if (!hit) return;
    site_at = at + 1 - len;
    if (slen < short_lim) begin
      lo = 0;
      hi = 64'(slen);
    end else begin
      lo = (site_at >= half_win) ? site_at - half_win : 0;
      hi = site_at + half_win;
      if (hi > slen) hi = 64'(slen);
    end
    r.match_pos    = site_at[31:0];
    r.range_start  = lo[31:0];
    r.range_end    = hi[31:0];
    r.match_number = seen;
    seen = seen + 32'd1;
    blocked = 5'(len - 1);
    pending_matches.insert(pending_matches.size(), r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function void check_match(ssw_pkg::result_t got);
    ssw_pkg::result_t want;
    if (pending_matches.size() == 0) begin
      $error("unexpected match at %0d", got.match_pos);
      fails++;
      return;
    end
    want = pending_matches.pop_front();
    compare_field("match_pos", want.match_pos, got.match_pos);
    compare_field("range_start", want.range_start, got.range_start);
    compare_field("range_end", want.range_end, got.range_end);
    compare_field("match_number", want.match_number, got.match_number);
  endfunction

  function void check_drained();
    if (pending_matches.size() != 0) begin
      $error("%0d expected matches never arrived", pending_matches.size());
      fails += pending_matches.size();
    end
  endfunction
endclass

module testbench;
  import ssw_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 102;
  localparam logic [31:0] BASES       = "ACGT";

  // shapes of the site pattern drawn per phase
  typedef enum {PAT_BASES, PAT_REPEAT, PAT_RANDOM, PAT_PAIR} pat_kind_t;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata   = '0;   // base [7:0], seq_len [39:8]
  logic         s_tuser   = 1'b0; // first
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [127:0] m_tdata;          // match_pos, range_start, range_end, match_number
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data  = '0;

  bit           s_idle = 1'b0;    // sender inserts random gaps
  bit           r_idle = 1'b0;    // receiver inserts random stalls
  int           quiet  = 0;       // cycles without any transaction
  logic [127:0] site_pat;         // pattern bytes currently configured
  int           site_len;         // effective pattern length
  logic [7:0]   seq_bytes [$];

  site_match_tracker tracker = new();

  site_search_window_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // monitor: results are checked before the byte of the same edge is noted,
  // since a match result is only registered once its last byte is taken
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (m_tvalid && m_tready) tracker.check_match(result_t'(m_tdata));
      if (s_tvalid && s_tready) tracker.note_byte(s_tdata[7:0], s_tdata[39:8], s_tuser);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      // watchdog on cycles where nothing moves on any channel
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[site_search_window_unit] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // receiver: random stall before each result, none while r_idle is clear
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = r_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one byte transaction; tvalid stays high into the next one when no gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic [31:0] slen, input logic first);
    int gap;
    gap = s_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {slen, b};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all five registers; the unit must be idle
  task automatic apply_config(input logic [63:0] plen_d, input logic [127:0] pat,
                              input logic [63:0] half_d, input logic [63:0] short_d);
    site_pat = pat;
    site_len = 32'(plen_d[4:0]);
    if (site_len < 1) site_len = 1;
    if (site_len > MAX_PATTERN_DEF) site_len = MAX_PATTERN_DEF;
    cfg_write(CFG_PATTERN_LENGTH, plen_d);
    cfg_write(CFG_PATTERN_LOW, pat[63:0]);
    cfg_write(CFG_PATTERN_HIGH, pat[127:64]);
    cfg_write(CFG_HALF_WINDOW, half_d);
    cfg_write(CFG_SHORT_LIMIT, short_d);
    cfg_valid <= 1'b0;
  endtask

  // drain: every expected match out, then a wait for the skid stage
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sometimes set the bits above a register's width, which must be ignored
  function automatic logic [63:0] pad_above(input logic [63:0] v, input int w);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) return v;
    return (junk << w) | v;
  endfunction

  // random configuration, then sequences built mostly from pattern copies and
  // pattern fragments so that matches, near misses and overlaps are common
  task automatic run_phase(input bit keep_seq);
    int          r;
    int          n;
    int          idx;
    int          items;
    logic [4:0]  plen;
    logic [15:0] half;
    logic [31:0] lim;
    logic [31:0] slen;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [127:0] pat;
    pat_kind_t   kind;
    bit          first;

    r = $urandom_range(0, 99);
    if (r < 10) plen = 5'd0;
    else if (r < 20) plen = 5'd1;
    else if (r < 75) plen = 5'($urandom_range(2, 8));
    else if (r < 85) plen = 5'd16;
    else plen = 5'($urandom_range(17, 31));

    kind = pat_kind_t'($urandom_range(0, 3));
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    for (idx = 0; idx < MAX_PATTERN_DEF; idx++) begin
      case (kind)
        PAT_BASES:  pat[8*idx +: 8] = BASES[8*$urandom_range(0, 3) +: 8];
        PAT_REPEAT: pat[8*idx +: 8] = b0;
        PAT_RANDOM: pat[8*idx +: 8] = 8'($urandom);
        default:    pat[8*idx +: 8] = idx[0] ? b1 : b0;
      endcase
    end

    r = $urandom_range(0, 99);
    if (r < 15) half = 16'd0;
    else if (r < 25) half = 16'hFFFF;
    else if (r < 70) half = 16'($urandom_range(0, 30));
    else half = 16'($urandom);

    r = $urandom_range(0, 99);
    if (r < 15) lim = 32'd0;
    else if (r < 25) lim = 32'hFFFF_FFFF;
    else if (r < 75) lim = $urandom_range(0, 80);
    else lim = $urandom;

    apply_config(pad_above(64'(plen), 5), pat, pad_above(64'(half), 16),
                 pad_above(64'(lim), 32));
    s_idle = ($urandom_range(0, 9) < 7);
    r_idle = ($urandom_range(0, 9) < 7);

    // a phase may carry on the sequence of the previous one
    first = !keep_seq;
    items = 0;
    while (items < PHASE_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 200) : $urandom_range(1, 60);
      // the phase ends at its item budget, cutting the last sequence short
      if (n > PHASE_ITEMS - items) n = PHASE_ITEMS - items;
      seq_bytes.delete();
      while (seq_bytes.size() < n) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          for (idx = 0; idx < site_len; idx++) begin
            seq_bytes.insert(seq_bytes.size(), site_pat[8*idx +: 8]);
          end
        end else if (r < 80) begin
          seq_bytes.insert(seq_bytes.size(), site_pat[8*$urandom_range(0, site_len - 1) +: 8]);
        end else if (r < 92) begin
          seq_bytes.insert(seq_bytes.size(), BASES[8*$urandom_range(0, 3) +: 8]);
        end else begin
          seq_bytes.insert(seq_bytes.size(), 8'($urandom));
        end
      end
      while (seq_bytes.size() > n) void'(seq_bytes.pop_back());
      // length field: mostly true, else off by a little, random or extreme,
      // which also puts bytes past the stated end
      r = $urandom_range(0, 99);
      if (r < 55) slen = seq_bytes.size();
      else if (r < 70) slen = seq_bytes.size() + $urandom_range(0, 10) - 5;
      else if (r < 85) slen = $urandom;
      else if (r < 92) slen = 32'd0;
      else slen = 32'hFFFF_FFFF;
      for (idx = 0; idx < seq_bytes.size(); idx++) begin
        if ($urandom_range(0, 19) == 0) slen = $urandom_range(0, 300);
        send_byte(seq_bytes[idx], slen, first);
        first = 1'b0;
      end
      items += seq_bytes.size();
      first = 1'b1;
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int i;
    int ph;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset pattern is six zero bytes: the match needs six bytes in the
    // sequence, and the zero byte right after it is still blocked
    for (i = 0; i < 7; i++) send_byte(8'h00, 32'd13, i == 0);
    wait_idle();

    // zero length acts as one, zero half window, no short sequences;
    // the last byte lies past a zero length so the window inverts
    apply_config(64'd0, 128'hFF, 64'd0, 64'd0);
    s_idle = 1'b1;
    r_idle = 1'b1;
    send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_byte(8'h00, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hFF, 32'd0, 1'b0);
    wait_idle();

    // length above the maximum is used as sixteen, widest window and limit
    apply_config(64'hFFFF_FFFF_FFFF_FFF4, {$urandom, $urandom, $urandom, $urandom},
                 '1, '1);
    for (i = 0; i < MAX_PATTERN_DEF; i++) send_byte(site_pat[8*i +: 8], 32'd100, i == 0);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) run_phase(ph > 0 && $urandom_range(0, 3) == 0);

    repeat (8) @(posedge clk);
    tracker.check_drained();
    if (tracker.fails == 0) begin
      $display("[site_search_window_unit] OK");
    end else begin
      $display("[site_search_window_unit] ERROR");
    end
    $finish;
  end

endmodule
